>>> src/iwf_pkg.sv
`timescale 1ns / 1ps
package iwf_pkg;

   localparam int KERNEL_SIZE_DEF = 3;
   localparam int MAX_WIDTH_DEF   = 1024;
   localparam int QUEUE_DEPTH     = 4;

   typedef enum logic [2:0] {
      CSR_WIDTH     = 3'd0,
      CSR_HEIGHT    = 3'd1,
      CSR_CHANNELS  = 3'd2,
      CSR_COEF_ROW0 = 3'd3,
      CSR_COEF_ROW1 = 3'd4,
      CSR_COEF_ROW2 = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic       start_of_frame;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] alpha_in;
   } req_payload_type;

   typedef struct packed {
      logic signed [27:0] red_result;
      logic signed [27:0] green_result;
      logic signed [27:0] blue_result;
      logic        [7:0]  alpha_result;
      logic               end_of_frame;
   } rsp_payload_type;

   // one full window handed from front to back
   typedef struct packed {
      logic [8:0][31:0] win;
      logic             last;
   } window_item_type;

endpackage

>>> src/iwf_ram.sv
`timescale 1ns / 1ps
module iwf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

>>> src/iwf_front.sv
`timescale 1ns / 1ps
// Stage 0 reads the line stores and classifies; stage 1 shifts the window.
module iwf_front #(
   parameter int MAX_WIDTH   = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  iwf_pkg::req_payload_type   in_data,
   input  logic                       advance,
   input  logic [10:0]                image_width,
   input  logic [15:0]                image_height,
   output logic                       win_valid,
   output iwf_pkg::window_item_type   win_item
);
   import iwf_pkg::*;

   localparam int KERNEL_SIZE = KERNEL_SIZE_DEF;
   localparam int AW = $clog2(MAX_WIDTH);
   localparam logic [13:0] MAXW = 14'(MAX_WIDTH);

   logic [10:0] column_count_ff, column_count_in;
   logic [15:0] row_count_ff, row_count_in;
   logic [13:0] width_eff;
   logic [15:0] height_eff;
   logic [13:0] col_cur;
   logic [15:0] row_cur;
   logic [31:0] pix;
   logic        emit, last, row_end;

   // stage 0 -> 1 registers
   logic        s1_valid_ff;
   logic [31:0] s1_pix_ff;
   logic [AW-1:0] s1_addr_ff;
   logic        s1_emit_ff, s1_last_ff;
   logic [31:0] ls0_rd, ls1_rd, ls0_fwd, ls1_fwd;
   logic        hz_ff;  // same column as item in stage 1

   logic [2:0][2:0][31:0] window_ff, window_in;
   logic        win_valid_ff, win_last_ff;

   always_comb begin
      width_eff = (image_width == 11'd0) ? 14'd1 : {3'd0, image_width};
      if (width_eff > MAXW) width_eff = MAXW;
      height_eff = (image_height == 16'd0) ? 16'd1 : image_height;
      col_cur = in_data.start_of_frame ? 14'd0 : 14'(column_count_ff % MAX_WIDTH);
      row_cur = in_data.start_of_frame ? 16'd0 : row_count_ff;
      pix = {in_data.alpha_in, in_data.blue_in, in_data.green_in, in_data.red_in};
      row_end = (col_cur + 14'd1) >= width_eff;
      emit = (row_cur >= 16'(KERNEL_SIZE - 1)) && (col_cur >= 14'(KERNEL_SIZE - 1))
         && (col_cur < width_eff) && (row_cur < height_eff);
      last = row_end && ({1'b0, row_cur} + 17'd1 >= {1'b0, height_eff});
      column_count_in = row_end ? 11'd0 : 11'(col_cur + 14'd1);
      if (!row_end) row_count_in = row_cur;
      else row_count_in = last ? 16'd0 : row_cur + 16'd1;
   end

   wire take = in_valid && advance;
   wire [AW-1:0] rd_addr = AW'(col_cur);

   iwf_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_line0 (
      .clock(clock), .wr_en(s1_valid_ff && advance), .wr_addr(s1_addr_ff),
      .wr_data(s1_pix_ff), .rd_en(take), .rd_addr(rd_addr), .rd_data(ls0_rd));
   iwf_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_line1 (
      .clock(clock), .wr_en(s1_valid_ff && advance), .wr_addr(s1_addr_ff),
      .wr_data(ls0_fwd), .rd_en(take), .rd_addr(rd_addr), .rd_data(ls1_rd));

   // forward the write still pending in stage 1 when the same column follows
   logic [31:0] byp0_ff, byp1_ff;
   assign ls0_fwd = hz_ff ? byp0_ff : ls0_rd;
   assign ls1_fwd = hz_ff ? byp1_ff : ls1_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         win_valid_ff    <= 1'b0;
         window_ff       <= '0;
         hz_ff           <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         if (in_valid) begin
            column_count_ff <= column_count_in;
            row_count_ff    <= row_count_in;
            hz_ff <= s1_valid_ff && (s1_addr_ff == rd_addr);
            byp0_ff <= s1_pix_ff;
            byp1_ff <= ls0_fwd;
         end
         win_valid_ff <= s1_valid_ff && s1_emit_ff;
         if (s1_valid_ff) window_ff <= window_in;
      end
      if (take) begin
         s1_pix_ff  <= pix;
         s1_addr_ff <= rd_addr;
         s1_emit_ff <= emit;
         s1_last_ff <= last;
      end
      if (advance && s1_valid_ff) win_last_ff <= s1_last_ff;
   end

   always_comb begin
      logic [2:0][31:0] vert;
      window_in = window_ff;
      vert = '0;
      for (int r = 0; r < KERNEL_SIZE - 1; r++) begin
         vert[r] = (((KERNEL_SIZE - 2 - r) % 2) == 0) ? ls0_fwd : ls1_fwd;
      end
      vert[KERNEL_SIZE-1] = s1_pix_ff;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
            window_in[r][c] = window_ff[r][c+1];
         end
         window_in[r][KERNEL_SIZE-1] = vert[r];
      end
   end

   assign win_valid = win_valid_ff;
   always_comb begin
      for (int i = 0; i < 9; i++) win_item.win[i] = window_ff[i/3][i%3];
      win_item.last = win_last_ff;
   end
endmodule

>>> src/iwf_queue.sv
`timescale 1ns / 1ps
module iwf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int AW = $clog2(DEPTH);
   logic [DEPTH-1:0][WIDTH-1:0] slot_ff;
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [$clog2(DEPTH+1)-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
      end
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end
   assign pop_data = slot_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;
endmodule

>>> src/iwf_back.sv
`timescale 1ns / 1ps
// Products registered, then one sum per channel, then output register.
module iwf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  iwf_pkg::window_item_type in_item,
   output logic                     in_ready,
   input  logic [2:0]               channel_count,
   input  logic [47:0]              coef_row0,
   input  logic [47:0]              coef_row1,
   input  logic [47:0]              coef_row2,
   output logic                     out_valid,
   output iwf_pkg::rsp_payload_type out_data,
   input  logic                     out_ready
);
   import iwf_pkg::*;

   logic [143:0] coefs;
   logic [2:0]   nfilt;
   logic         p_valid_ff, o_valid_ff;
   logic signed [2:0][8:0][24:0] prod_ff;
   logic [7:0]   p_alpha_ff;
   logic         p_last_ff;
   rsp_payload_type o_data_ff, o_data_in;
   wire p_go = !p_valid_ff || !o_valid_ff || out_ready;
   wire o_go = !o_valid_ff || out_ready;

   assign coefs = {coef_row2, coef_row1, coef_row0};
   assign nfilt = (channel_count > 3'd3) ? 3'd3 : channel_count;
   assign in_ready = p_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (p_go) p_valid_ff <= in_valid;
         if (o_go) o_valid_ff <= p_valid_ff;
      end
      if (p_go && in_valid) begin
         for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 9; i++) begin
               prod_ff[ch][i] <= (ch < nfilt)
                  ? 25'($signed({1'b0, in_item.win[i][8*ch +: 8]})
                     * $signed(coefs[16*i +: 16]))
                  : 25'sd0;
            end
         end
         p_alpha_ff <= (channel_count >= 3'd4) ? in_item.win[4][31:24] : 8'd0;
         p_last_ff  <= in_item.last;
      end
      if (o_go && p_valid_ff) o_data_ff <= o_data_in;
   end

   always_comb begin
      logic signed [2:0][27:0] acc;
      for (int ch = 0; ch < 3; ch++) begin
         acc[ch] = '0;
         for (int i = 0; i < 9; i++) begin
            acc[ch] = acc[ch] + 28'($signed(prod_ff[ch][i]));
         end
      end
      o_data_in.red_result   = acc[0];
      o_data_in.green_result = acc[1];
      o_data_in.blue_result  = acc[2];
      o_data_in.alpha_result = p_alpha_ff;
      o_data_in.end_of_frame = p_last_ff;
   end

   assign out_valid = o_valid_ff;
   assign out_data  = o_data_ff;
endmodule

>>> src/image_window_filter_top.sv
`timescale 1ns / 1ps
// channel | ports                    | accepted when
// req     | req_push, req_full, data | req_push && !req_full
// rsp     | rsp_pop, rsp_empty, data | rsp_pop && !rsp_empty
// csr     | csr_valid, csr_ready     | csr_valid && csr_ready
// One pixel per cycle while req_full is low; the pixel completing a window
// passes stage 1, the window register, the queue, then product and output regs.
// Rate set by the line stores' read ports and window shift: 1 item/cycle.
// Reset is synchronous; line stores are not cleared.
// req_full rises only when the window queue holds over QUEUE_DEPTH-3 items under rsp stall.
module image_window_filter_top #(
   parameter int MAX_WIDTH   = iwf_pkg::MAX_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  iwf_pkg::req_payload_type req_data,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output iwf_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [47:0]              csr_data
);
   import iwf_pkg::*;

   localparam int QW = $bits(window_item_type);
   localparam int QCW = $clog2(QUEUE_DEPTH+1);
   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic [2:0]  chan_ff;
   logic [47:0] coef0_ff, coef1_ff, coef2_ff;
   logic        win_valid, q_empty, back_ready;
   window_item_type win_item;
   logic [QW-1:0] q_out;
   logic [QCW-1:0] q_count;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1024;
         height_ff <= 16'd480;
         chan_ff   <= 3'd4;
         coef0_ff  <= '0;
         coef1_ff  <= 48'd268435456;
         coef2_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WIDTH:     width_ff  <= csr_data[10:0];
            CSR_HEIGHT:    height_ff <= csr_data[15:0];
            CSR_CHANNELS:  chan_ff   <= csr_data[2:0];
            CSR_COEF_ROW0: coef0_ff  <= csr_data;
            CSR_COEF_ROW1: coef1_ff  <= csr_data;
            CSR_COEF_ROW2: coef2_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // front pipe holds up to 2 items in flight; reserve that room in the queue
   assign req_full = (q_count > QCW'(QUEUE_DEPTH - 3));

   iwf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock(clock), .reset(reset), .in_valid(req_push && !req_full),
      .in_data(req_data), .advance(1'b1), .image_width(width_ff),
      .image_height(height_ff), .win_valid(win_valid), .win_item(win_item));

   iwf_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(win_valid), .push_data(win_item),
      .pop(!q_empty && back_ready), .pop_data(q_out), .empty(q_empty),
      .count(q_count));

   logic out_valid;
   iwf_back u_back (
      .clock(clock), .reset(reset), .in_valid(!q_empty), .in_item(q_out),
      .in_ready(back_ready), .channel_count(chan_ff), .coef_row0(coef0_ff),
      .coef_row1(coef1_ff), .coef_row2(coef2_ff), .out_valid(out_valid),
      .out_data(rsp_data), .out_ready(rsp_pop));
   assign rsp_empty = !out_valid;
endmodule

>>> src/iwf_checker.sv
`timescale 1ns / 1ps
module iwf_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_push,
   input logic                     req_full,
   input logic                     rsp_empty,
   input logic                     rsp_pop,
   input iwf_pkg::rsp_payload_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("result changed while stalled");
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result after reset");
   a_reset_free: assert property (@(posedge clock) reset |=> !req_full)
      else $error("full after reset");
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_push, req_full, rsp_empty, rsp_pop}))
      else $error("unknown handshake");
endmodule

bind image_window_filter_top iwf_checker u_checker (
   .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
   .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data));

>>> verif/tb_image_window_filter_top.sv
`timescale 1ns / 1ps
module tb_image_window_filter_top;
   import iwf_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_CYCLES = 20;

   class window_scoreboard;
      bit [31:0] line_mem[2][1024];
      bit [31:0] win[3][3];
      int unsigned col_cnt, row_cnt;
      bit [10:0] width_reg;
      bit [15:0] height_reg;
      bit [2:0]  chan_reg;
      bit [47:0] coef[3];
      rsp_payload_type expected_q[$];
      int errors;

      function new();
         width_reg  = 11'd1024;
         height_reg = 16'd480;
         chan_reg   = 3'd4;
         coef[0]    = 48'd0;
         coef[1]    = 48'd268435456;
         coef[2]    = 48'd0;
         col_cnt    = 0;
         row_cnt    = 0;
         errors     = 0;
      endfunction

      function void write_reg(csr_index_type idx, bit [47:0] v);
         case (idx)
            CSR_WIDTH:     width_reg = v[10:0];
            CSR_HEIGHT:    height_reg = v[15:0];
            CSR_CHANNELS:  chan_reg = v[2:0];
            CSR_COEF_ROW0: coef[0] = v;
            CSR_COEF_ROW1: coef[1] = v;
            CSR_COEF_ROW2: coef[2] = v;
            default: ;
         endcase
      endfunction

      // runs one pixel through the window and queues the filtered output, if any
      function void note_pixel(req_payload_type p);
         int unsigned w, h, col, row, nfilt;
         bit [31:0] pix;
         bit [31:0] vert[3];
         bit emit, last;
         int acc;
         logic signed [15:0] k;
         bit [7:0] s;
         rsp_payload_type e;
         w = width_reg;
         h = height_reg;
         if (w == 0) w = 1;
         if (w > 1024) w = 1024;
         if (h == 0) h = 1;
         if (p.start_of_frame) begin
            col_cnt = 0;
            row_cnt = 0;
         end
         col = col_cnt % 1024;
         row = row_cnt;
         pix = {p.alpha_in, p.blue_in, p.green_in, p.red_in};
         vert[0] = line_mem[1][col];
         vert[1] = line_mem[0][col];
         vert[2] = pix;
         for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
            win[r][2] = vert[r];
         end
         line_mem[1][col] = line_mem[0][col];
         line_mem[0][col] = pix;
         emit = (row >= 2) && (col >= 2) && (col < w) && (row < h);
         last = (col + 1 >= w) && (row + 1 >= h);
         if (col + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (row + 1 >= h) ? 0 : row + 1;
         end else begin
            col_cnt = col + 1;
         end
         if (!emit) return;
         nfilt = (chan_reg > 3) ? 3 : chan_reg;
         e = '0;
         for (int ch = 0; ch < 3; ch++) begin
            acc = 0;
            if (ch < nfilt) begin
               for (int r = 0; r < 3; r++)
                  for (int c = 0; c < 3; c++) begin
                     s = win[r][c][8*ch +: 8];
                     k = coef[r][16*c +: 16];
                     acc = acc + int'(s) * int'(k);
                  end
            end
            case (ch)
               0: e.red_result = acc[27:0];
               1: e.green_result = acc[27:0];
               default: e.blue_result = acc[27:0];
            endcase
         end
         e.alpha_result = (chan_reg >= 4) ? win[1][1][31:24] : 8'd0;
         e.end_of_frame = last;
         expected_q.push_back(e);
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type e;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result %h", got);
            return;
         end
         e = expected_q.pop_front();
         if (got.red_result !== e.red_result || got.green_result !== e.green_result ||
             got.blue_result !== e.blue_result || got.alpha_result !== e.alpha_result ||
             got.end_of_frame !== e.end_of_frame) begin
            errors++;
            if (errors <= 10)
               $display("mismatch exp r=%h g=%h b=%h a=%h eof=%b got r=%h g=%h b=%h a=%h eof=%b",
                        e.red_result, e.green_result, e.blue_result, e.alpha_result,
                        e.end_of_frame, got.red_result, got.green_result, got.blue_result,
                        got.alpha_result, got.end_of_frame);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_push;
   logic req_full;
   req_payload_type req_data;
   logic rsp_empty;
   logic rsp_pop;
   rsp_payload_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [2:0] csr_index;
   logic [47:0] csr_data;

   window_scoreboard sb;
   bit calm;
   int unsigned cycle_cnt = 0;
   int unsigned sent;

   image_window_filter_top dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side: check accepted items, then pick next pop
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) sb.check_result(rsp_data);
         rsp_pop <= calm || ($urandom_range(99) >= 34);
      end
   end

   task automatic write_csr(csr_index_type idx, bit [47:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(idx, v);
   endtask

   task automatic configure(bit [10:0] w, bit [15:0] h, bit [2:0] ch,
                            bit [47:0] c0, bit [47:0] c1, bit [47:0] c2);
      write_csr(CSR_WIDTH, 48'(w));
      write_csr(CSR_HEIGHT, 48'(h));
      write_csr(CSR_CHANNELS, 48'(ch));
      write_csr(CSR_COEF_ROW0, c0);
      write_csr(CSR_COEF_ROW1, c1);
      write_csr(CSR_COEF_ROW2, c2);
   endtask

   task automatic send_pixel(req_payload_type p);
      if (!calm && $urandom_range(99) < 34) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 34);
      end
      req_push <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (req_full);
      sb.note_pixel(p);
      sent++;
   endtask

   function automatic req_payload_type rand_pixel(bit sof);
      req_payload_type p;
      p.start_of_frame = sof;
      p.red_in   = 8'($urandom);
      p.green_in = 8'($urandom);
      p.blue_in  = 8'($urandom);
      p.alpha_in = 8'($urandom);
      return p;
   endfunction

   // n pixels starting a fresh frame; stray start marks now and then
   task automatic stream(int n, int sof_pct);
      for (int i = 0; i < n; i++)
         send_pixel(rand_pixel(i == 0 || $urandom_range(99) < sof_pct));
      req_push <= 1'b0;
   endtask

   task automatic settle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic bit [15:0] rand_coef();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic bit [47:0] rand_row();
      return {rand_coef(), rand_coef(), rand_coef()};
   endfunction

   initial begin
      req_payload_type p;
      sb = new();
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_WIDTH;
      csr_data = '0;
      calm = 1'b0;
      sent = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // center-tap kernel (4096) from reset, smallest frame, extreme samples
      write_csr(CSR_WIDTH, 48'd3);
      write_csr(CSR_HEIGHT, 48'd3);
      for (int i = 0; i < 9; i++) begin
         p = '0;
         p.start_of_frame = (i == 0);
         p.red_in = (i % 2) ? 8'hFF : 8'h00;
         p.green_in = (i % 3) ? 8'h00 : 8'hFF;
         p.blue_in = 8'hFF;
         p.alpha_in = (i == 4) ? 8'hFF : 8'h5A;
         send_pixel(p);
      end
      req_push <= 1'b0;
      settle();

      // largest coefficients against full-scale samples, then smallest against random ones
      configure(11'd3, 16'd3, 3'd3, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
      for (int i = 0; i < 9; i++) begin
         p = '1;
         p.start_of_frame = (i == 0);
         send_pixel(p);
      end
      req_push <= 1'b0;
      settle();
      configure(11'd3, 16'd3, 3'd7, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
      stream(9, 0);
      settle();
      configure(11'd4, 16'd3, 3'd0, rand_row(), rand_row(), rand_row());
      stream(12, 0);
      settle();
      configure(11'd3, 16'd4, 3'd1, rand_row(), rand_row(), rand_row());
      stream(12, 0);
      settle();

      // degenerate sizes give no output
      configure(11'd0, 16'd0, 3'd2, rand_row(), rand_row(), rand_row());
      stream(8, 0);
      settle();
      configure(11'd2, 16'd5, 3'd4, rand_row(), rand_row(), rand_row());
      stream(10, 0);
      settle();
      configure(11'd6, 16'd2, 3'd4, rand_row(), rand_row(), rand_row());
      stream(14, 0);
      settle();

      // tallest frame
      configure(11'd3, 16'd65535, 3'd4, rand_row(), rand_row(), rand_row());
      stream(40, 0);
      settle();

      while (sent < 1350) begin
         int w, h, n;
         w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
         h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
         n = $urandom_range(2, 4) * ((w < 1 ? 1 : w) * (h < 1 ? 1 : h));
         calm = (sent >= 600 && sent < 900);
         configure(11'(w), 16'(h), 3'($urandom_range(7)), rand_row(), rand_row(),
                   rand_row());
         stream(n, $urandom_range(3) == 0 ? 3 : 0);
         settle();
      end
      calm = 1'b0;
      settle();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
